FILE: src/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, calendar constants and the month length function of the
// calendar clock.
// ----------------------------------------------------------------------------
package cca_pkg;

  // field widths
  localparam int YearW = 16;
  localparam int MonW  = 4;
  localparam int DayW  = 5;
  localparam int HourW = 5;
  localparam int MinW  = 6;
  localparam int SecW  = 6;
  localparam int AdvW  = 8;
  // seconds sum: up to 63 + 255
  localparam int SumW  = 9;

  // packed stream widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

  // calendar limits
  localparam logic [SumW-1:0]  SecPerMin  = 9'd60;
  localparam logic [MinW-1:0]  MinPerHour = 6'd60;
  localparam logic [HourW-1:0] HourPerDay = 5'd24;
  localparam logic [MonW:0]    MonPerYear = 5'd12;
  localparam logic [DayW-1:0]  FirstDay   = 5'd1;
  localparam logic [MonW-1:0]  FirstMonth = 4'd1;

  // month numbers with a length other than 31 days
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonApr = 4'd4;
  localparam logic [MonW-1:0] MonJun = 4'd6;
  localparam logic [MonW-1:0] MonSep = 4'd9;
  localparam logic [MonW-1:0] MonNov = 4'd11;

  // divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare
  localparam logic [YearW-1:0] Div25Inv = 16'd23593;
  localparam logic [YearW-1:0] Div25Max = 16'd2621;

  // reset time 2000-01-01 00:00:00
  localparam logic [YearW-1:0] ResetYear = 16'd2000;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
  } cal_time_t;

  // days in a month; unknown month codes count as 31 days
  function automatic logic [DayW-1:0] month_days(input logic [MonW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] days;
    case (month) inside
      MonApr, MonJun, MonSep, MonNov: days = 5'd30;
      MonFeb:                         days = leap ? 5'd29 : 5'd28;
      default:                        days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

FILE: src/calendar_clock_advance_top.sv
// ----------------------------------------------------------------------------
// calendar_clock_advance_top
// Calendar clock: loads a new time or advances by 0 to 255 seconds, with
// carries through minutes, hours, days, months and years.
// ----------------------------------------------------------------------------
// channel  direction  tdata                                 tuser
// s_axis   in         adv, year, month, day, hour, min, sec mode
// m_axis   out        year, month, day, hour, min, sec      -
//
// A load passes the time register, then the result register. An advance
// makes n = (seconds + advance) / 60 passes (at most 5) of the shared carry
// unit, one per minute carried. The input is ready again as the result
// register loads. Reset gives 2000-01-01 00:00:00.
// A new item is taken while a result still waits on m_axis; a stalled
// output holds the sequencer in its last state until the register frees.
// ----------------------------------------------------------------------------
module calendar_clock_advance_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // advance_seconds[7:0], set_year[23:8], set_month[27:24], set_day[32:28],
  // set_hours[37:33], set_minutes[43:38], set_seconds[49:44], zero pad
  input  logic [cca_pkg::InDataW-1:0]   s_axis_tdata,
  // mode[0]
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // now_year[15:0], now_month[19:16], now_day[24:20], now_hours[29:25],
  // now_minutes[35:30], now_seconds[41:36], zero pad
  output logic [cca_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cca_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StRun    = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]          state_d, state_q;
  cal_time_t           time_d, time_q;
  cal_time_t           step_nxt;
  logic [SumW-1:0]     sum_d, sum_q;
  logic                leap;
  logic                in_xfer;
  logic                out_free;
  logic                oval_d, oval_q;
  logic [OutDataW-1:0] odata_d, odata_q;
  cal_time_t           ld_time;

  // input field unpack
  assign ld_time.year    = s_axis_tdata[23:8];
  assign ld_time.month   = s_axis_tdata[27:24];
  assign ld_time.day     = s_axis_tdata[32:28];
  assign ld_time.hours   = s_axis_tdata[37:33];
  assign ld_time.minutes = s_axis_tdata[43:38];
  assign ld_time.seconds = s_axis_tdata[49:44];

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !oval_q || m_axis_tready;

  cca_leap u_leap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .year_i (time_q.year),
    .leap_o (leap)
  );

  cca_step u_step (
    .cur_i  (time_q),
    .leap_i (leap),
    .nxt_o  (step_nxt)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    time_d  = time_q;
    sum_d   = sum_q;
    oval_d  = oval_q;
    odata_d = odata_q;
    if (oval_q && m_axis_tready) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (s_axis_tuser) begin
            time_d  = ld_time;
            state_d = StFinish;
          end else begin
            sum_d   = {3'b000, time_q.seconds} + {1'b0, s_axis_tdata[AdvW-1:0]};
            state_d = StRun;
          end
        end
      end
      StRun: begin
        if (sum_q >= SecPerMin) begin
          time_d = step_nxt;
          sum_d  = sum_q - SecPerMin;
        end else begin
          time_d.seconds = sum_q[SecW-1:0];
          state_d        = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          oval_d  = 1'b1;
          odata_d = {6'b000000, time_q.seconds, time_q.minutes, time_q.hours,
                     time_q.day, time_q.month, time_q.year};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control and time registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oval_q  <= 1'b0;
      time_q  <= '{year: ResetYear, month: FirstMonth, day: FirstDay,
                   hours: '0, minutes: '0, seconds: '0};
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
      time_q  <= time_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = odata_q;

endmodule

FILE: src/cca_leap.sv
// ----------------------------------------------------------------------------
// cca_leap
// Registered leap-year flag of the current year (Gregorian rule).
// ----------------------------------------------------------------------------
module cca_leap (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [cca_pkg::YearW-1:0] year_i,
  output logic                    leap_o
);
  import cca_pkg::*;

  logic [YearW-1:0] prod;
  logic             div25;
  logic             leap_d, leap_q;

  // year divisible by 25 when year * inv(25) mod 2^16 stays small
  assign prod   = year_i * Div25Inv;
  assign div25  = (prod <= Div25Max);
  // by 4, and not by 100 unless by 400
  assign leap_d = (year_i[1:0] == 2'b00) && (!div25 || (year_i[3:0] == 4'b0000));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leap_q <= 1'b1;
    end else begin
      leap_q <= leap_d;
    end
  end

  assign leap_o = leap_q;

endmodule

FILE: src/cca_step.sv
// ----------------------------------------------------------------------------
// cca_step
// Shared carry unit: adds one minute to the time and ripples the carry
// through hours, days, months and years.
// ----------------------------------------------------------------------------
module cca_step (
  input  cca_pkg::cal_time_t cur_i,
  input  logic               leap_i,
  output cca_pkg::cal_time_t nxt_o
);
  import cca_pkg::*;

  logic [MinW-1:0]  min_inc;
  logic [HourW-1:0] hour_inc;
  logic [DayW:0]    day_inc;
  logic [MonW:0]    mon_inc;
  logic [DayW-1:0]  mdays;

  assign min_inc  = cur_i.minutes + 6'd1;
  assign hour_inc = cur_i.hours + 5'd1;
  assign day_inc  = {1'b0, cur_i.day} + 6'd1;
  assign mon_inc  = {1'b0, cur_i.month} + 5'd1;
  assign mdays    = month_days(cur_i.month, leap_i);

  // carry ripple
  always_comb begin
    nxt_o = cur_i;
    if (min_inc < MinPerHour) begin
      nxt_o.minutes = min_inc;
    end else begin
      nxt_o.minutes = '0;
      if (hour_inc < HourPerDay) begin
        nxt_o.hours = hour_inc;
      end else begin
        nxt_o.hours = '0;
        if (day_inc <= {1'b0, mdays}) begin
          nxt_o.day = day_inc[DayW-1:0];
        end else begin
          nxt_o.day = FirstDay;
          if (mon_inc <= MonPerYear) begin
            nxt_o.month = mon_inc[MonW-1:0];
          end else begin
            nxt_o.month = FirstMonth;
            nxt_o.year  = cur_i.year + 16'd1;
          end
        end
      end
    end
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the calendar clock. A scoreboard class keeps its own
// copy of the date and time, predicts the time after every load or advance
// transfer and checks each output transfer field by field. Directed loads
// cover the calendar edges and out-of-range values, then random loads and
// advances run with random idle bursts on both sides of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import cca_pkg::*;

  // tuser values on the input side
  localparam logic ModeAdvance = 1'b0;
  localparam logic ModeLoad    = 1'b1;

  localparam int RandomItems = 800;
  localparam int CalmItems   = 100;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 20;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // advance_seconds, set_year, set_month, set_day, set_hours, set_minutes,
  // set_seconds, zero pad
  logic [InDataW-1:0]  s_axis_tdata;
  // mode
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // now_year, now_month, now_day, now_hours, now_minutes, now_seconds, zero pad
  logic [OutDataW-1:0] m_axis_tdata;

  // no idling on either side once set
  bit calm;

  // --------------------------------------------------------------------------
  // calendar predictor and store of expected times
  // --------------------------------------------------------------------------
  class calendar_scoreboard;
    cal_time_t   clock_now;
    cal_time_t   expected_times[$];
    int unsigned errors;
    int unsigned loads;
    int unsigned advances;
    int unsigned minute_carries;
    int unsigned results_checked;

    function new();
      clock_now.year    = ResetYear;
      clock_now.month   = FirstMonth;
      clock_now.day     = FirstDay;
      clock_now.hours   = '0;
      clock_now.minutes = '0;
      clock_now.seconds = '0;
      errors = 0;
      loads = 0;
      advances = 0;
      minute_carries = 0;
      results_checked = 0;
    endfunction

    function int unsigned pending();
      return expected_times.size();
    endfunction

    function bit leap_year(logic [YearW-1:0] y);
      if (y % 4 != 0) return 1'b0;
      if (y % 100 != 0) return 1'b1;
      return (y % 400 == 0);
    endfunction

    // invalid month codes count as 31 days
    function int unsigned days_in_month(logic [MonW-1:0] m, logic [YearW-1:0] y);
      if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) return 30;
      if (m == MonFeb) return leap_year(y) ? 29 : 28;
      return 31;
    endfunction

    // one minute carry rippling up through hours, days, months and years
    function void carry_minute();
      int unsigned m;
      int unsigned h;
      int unsigned d;
      int unsigned mo;
      m = (clock_now.minutes + 1) & 'h3f;
      if (m < 60) begin
        clock_now.minutes = 6'(m);
        return;
      end
      clock_now.minutes = '0;
      h = (clock_now.hours + 1) & 'h1f;
      if (h < 24) begin
        clock_now.hours = 5'(h);
        return;
      end
      clock_now.hours = '0;
      d = clock_now.day + 1;
      if (d <= days_in_month(clock_now.month, clock_now.year)) begin
        clock_now.day = 5'(d & 'h1f);
        return;
      end
      clock_now.day = FirstDay;
      mo = clock_now.month + 1;
      if (mo <= 12) begin
        clock_now.month = 4'(mo);
        return;
      end
      clock_now.month = FirstMonth;
      clock_now.year  = clock_now.year + 16'd1;
    endfunction

    // accepted input transfer: update the clock and queue the expected time
    function void note_input(logic mode, logic [InDataW-1:0] data);
      int unsigned sum;
      if (mode == ModeLoad) begin
        loads++;
        clock_now.year    = data[23:8];
        clock_now.month   = data[27:24];
        clock_now.day     = data[32:28];
        clock_now.hours   = data[37:33];
        clock_now.minutes = data[43:38];
        clock_now.seconds = data[49:44];
      end else begin
        advances++;
        sum = clock_now.seconds + data[7:0];
        while (sum >= 60) begin
          sum -= 60;
          minute_carries++;
          carry_minute();
        end
        clock_now.seconds = 6'(sum);
      end
      expected_times.push_back(clock_now);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // accepted output transfer: compare with the oldest expected time
    function void check_result(logic [OutDataW-1:0] data);
      cal_time_t want;
      if (expected_times.size() == 0) begin
        $error("output transfer with no expected time: %h", data);
        errors++;
        return;
      end
      want = expected_times.pop_front();
      results_checked++;
      compare_field("now_year",    want.year,          data[15:0]);
      compare_field("now_month",   16'(want.month),    16'(data[19:16]));
      compare_field("now_day",     16'(want.day),      16'(data[24:20]));
      compare_field("now_hours",   16'(want.hours),    16'(data[29:25]));
      compare_field("now_minutes", 16'(want.minutes),  16'(data[35:30]));
      compare_field("now_seconds", 16'(want.seconds),  16'(data[41:36]));
    endfunction
  endclass

  calendar_scoreboard sb;

  calendar_clock_advance_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_input(s_axis_tuser, s_axis_tdata);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("timeout: no transfer for %0d cycles", StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // output side: random stall bursts until the calm part
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [InDataW-1:0] pack_item(logic [7:0] adv, logic [15:0] y,
                                                   logic [3:0] mo, logic [4:0] d,
                                                   logic [4:0] h, logic [5:0] mi,
                                                   logic [5:0] s);
    return {6'd0, s, mi, h, d, mo, y, adv};
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(input logic mode, input logic [InDataW-1:0] data);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // load a time; the advance field carries random bits that must be ignored
  task automatic load_time(input logic [15:0] y, input logic [3:0] mo, input logic [4:0] d,
                           input logic [4:0] h, input logic [5:0] mi, input logic [5:0] s);
    send_item(ModeLoad, pack_item(8'($urandom_range(0, 255)), y, mo, d, h, mi, s));
  endtask

  // advance; the load fields carry random bits that must be ignored
  task automatic advance_by(input logic [7:0] adv);
    send_item(ModeAdvance, pack_item(adv, 16'($urandom), 4'($urandom), 5'($urandom),
                                     5'($urandom), 6'($urandom), 6'($urandom)));
  endtask

  // random load, mostly close to a calendar boundary
  task automatic random_load();
    logic [15:0] y;
    logic [3:0]  mo;
    logic [4:0]  d;
    logic [4:0]  h;
    logic [5:0]  mi;
    logic [5:0]  s;
    if ($urandom_range(0, 4) == 0) begin
      // anything the fields can hold
      load_time(16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                6'($urandom), 6'($urandom));
    end else begin
      case ($urandom_range(0, 7))
        0: y = 16'hffff;
        1: y = 16'd1900;
        2: y = 16'd2000;
        3: y = 16'd2100;
        4: y = 16'd2400;
        5: y = 16'(4 * $urandom_range(0, 16383));
        default: y = 16'($urandom);
      endcase
      mo = 4'($urandom_range(1, 12));
      d  = 5'($urandom_range(0, 3) == 0 ? $urandom_range(1, 31) : $urandom_range(27, 31));
      h  = $urandom_range(0, 1) == 0 ? 5'd23 : 5'($urandom_range(0, 23));
      mi = 6'($urandom_range(0, 1) == 0 ? $urandom_range(56, 59) : $urandom_range(0, 59));
      s  = 6'($urandom_range(0, 59));
      load_time(y, mo, d, h, mi, s);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    calm = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= ModeAdvance;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset time, advance extremes
    advance_by(8'd0);
    advance_by(8'd255);
    // all-zero load with month and day zero, then the largest advance
    load_time(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    advance_by(8'd255);
    // year wrap at the end of the last year
    load_time(16'hffff, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    advance_by(8'd1);
    // all ones: widest seconds sum, minute 63 wraps without an hour carry
    load_time(16'hffff, 4'hf, 5'h1f, 5'h1f, 6'h3f, 6'h3f);
    advance_by(8'd255);
    // leap rules: by 400, by 100, by 4
    load_time(16'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    advance_by(8'd1);
    advance_by(8'd255);
    load_time(16'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd30);
    advance_by(8'd30);
    load_time(16'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    advance_by(8'd1);
    load_time(16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
    advance_by(8'd60);
    // loaded day past the month length
    load_time(16'd2023, 4'd4, 5'd31, 5'd23, 6'd59, 6'd59);
    advance_by(8'd1);
    // invalid month thirteen counts 31 days and carries a year
    load_time(16'd2023, 4'd13, 5'd31, 5'd23, 6'd59, 6'd59);
    advance_by(8'd1);
    // out-of-range hour and minute
    load_time(16'd2023, 4'd6, 5'd15, 5'd24, 6'd60, 6'd59);
    advance_by(8'd121);

    // random part; the last stretch runs without idling
    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - CalmItems) calm = 1'b1;
      if ($urandom_range(0, 99) < 30) begin
        random_load();
      end else begin
        case ($urandom_range(0, 9))
          0: advance_by(8'd255);
          1: advance_by(8'd0);
          default: advance_by(8'($urandom_range(0, 255)));
        endcase
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d loads and %0d advances with %0d minute carries",
             sb.loads, sb.advances, sb.minute_carries);
    $display("%0d output transfers checked, %0d mismatches", sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
